// ===== hdl/assert_macros.svh =====
// Assertion macros, used by the top-level RTL file of the block.
// Define ASSERT_OFF to compile the assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ===== hdl/tli_pkg.sv =====
// Package of the table interpolation block: widths, command codes, status codes,
// and the controller-to-datapath command and status structs. No dependencies.
`default_nettype none
package tli_pkg;
  localparam int TableDepth = 256;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam int DataW = 32;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [1:0] StInside = 2'd0;
  localparam logic [1:0] StLow = 2'd1;
  localparam logic [1:0] StHigh = 2'd2;

  // Read-port and datapath step selection.
  typedef struct packed {
    logic             write;     // store the load item
    logic             latch_q;   // capture query
    logic             rd_en;
    logic [IdxW-1:0]  rd_addr;
    logic [2:0]       rd_dst;    // which register takes the read data
    logic             div_start;
    logic             div_step;
    logic             finish;    // form the result
  } cmd_t;

  typedef struct packed {
    logic q_lt_x;     // query below read x (registered x)
    logic q_gt_x;
    logic dx_zero;
    logic div_done;
  } sts_t;

  localparam logic [2:0] DstX0 = 3'd0;
  localparam logic [2:0] DstY0 = 3'd1;
  localparam logic [2:0] DstXl = 3'd2;
  localparam logic [2:0] DstYl = 3'd3;
  localparam logic [2:0] DstXm = 3'd4;
  localparam logic [2:0] DstXa = 3'd5;
  localparam logic [2:0] DstYa = 3'd6;
  localparam logic [2:0] DstXb = 3'd7;
endpackage
`default_nettype wire

// ===== hdl/table_linear_interpolation.sv =====
// Piecewise-linear interpolation over a loaded breakpoint table.
// Channels: an input item with command_i 0 stores point_x_i/point_y_i at
// point_index_i and gives no result; command_i 1 queries at query_x_i and
// gives one result item (result_y_o, range_status_o, segment_index_o).
// Both channels use valid/stall; an item moves when valid is high and stall low.
// point_count is written through cfg_we_i/cfg_wdata_i; write it only while the
// block is idle (the block itself does not enforce this). A load stores the item
// and passes through a gap state before the next item is taken. A query clamped
// below the first or above the last point skips the search. Otherwise the binary
// search runs up to ceil(log2(point_count)) probes (one memory read port); a query
// landing on the last point then finishes, and one inside a segment goes on with
// the segment-end reads and the bit-serial 66-bit divider.
// One item is in work at a time; the result waits in the output register while
// out_stall_i is high and input stays stalled until it is taken.
// Reset sets point_count to 2 and returns to idle; the table contents are
// undefined until loaded.
`default_nettype none
`include "assert_macros.svh"
module table_linear_interpolation (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                command_i,
  input  wire [7:0]          point_index_i,
  input  wire signed [31:0]  point_x_i,
  input  wire signed [31:0]  point_y_i,
  input  wire signed [31:0]  query_x_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] result_y_o,
  output logic [1:0]         range_status_o,
  output logic [7:0]         segment_index_o,
  input  wire                cfg_we_i,
  input  wire [8:0]          cfg_wdata_i
);
  import tli_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [1:0] status;
  logic [7:0] seg;
  logic use_last;

  tli_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .out_valid_o,
    .out_stall_i, .cfg_we_i, .cfg_wdata_i, .sts_i(sts), .cmd_o(cmd),
    .status_o(status), .seg_o(seg), .use_last_o(use_last)
  );

  tli_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .point_index_i, .point_x_i,
    .point_y_i, .query_x_i, .status_i(status), .seg_i(seg), .use_last_i(use_last),
    .result_y_o, .range_status_o, .segment_index_o
  );

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, out_valid_o |-> in_stall_o)
  `ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(result_y_o))
  `ASSERT_IMPL(a_status_ok, clk_i, rst_ni, out_valid_o |-> range_status_o != 2'd3)
endmodule
`default_nettype wire

// ===== hdl/tli_datapath.sv =====
// Datapath: breakpoint memories, compare, 66-bit product, serial divider
// and result formation. Depends on tli_pkg.
`default_nettype none
module tli_datapath (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  tli_pkg::cmd_t          cmd_i,
  output tli_pkg::sts_t          sts_o,
  input  wire [7:0]              point_index_i,
  input  wire signed [31:0]      point_x_i,
  input  wire signed [31:0]      point_y_i,
  input  wire signed [31:0]      query_x_i,
  input  wire [1:0]              status_i,
  input  wire [7:0]              seg_i,
  input  wire                    use_last_i,
  output logic signed [31:0]     result_y_o,
  output logic [1:0]             range_status_o,
  output logic [7:0]             segment_index_o
);
  import tli_pkg::*;

  logic [DataW-1:0] xmem [TableDepth];
  logic [DataW-1:0] ymem [TableDepth];
  logic [DataW-1:0] xr_q, yr_q;
  logic [2:0] dst_q;
  logic rv_q;
  logic signed [31:0] q_q, x0_q, y0_q, xl_q, yl_q, xm_q, xa_q, ya_q, xb_q, yb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      xmem[point_index_i[IdxW-1:0]] <= point_x_i;
      ymem[point_index_i[IdxW-1:0]] <= point_y_i;
    end
    if (cmd_i.rd_en) begin
      xr_q <= xmem[cmd_i.rd_addr];
      yr_q <= ymem[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      dst_q <= DstX0;
    end else begin
      rv_q <= cmd_i.rd_en;
      dst_q <= cmd_i.rd_dst;
    end
  end

  // Capture the registered read data (xr_q/yr_q), routed by the delayed destination dst_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_q) q_q <= query_x_i;
    if (rv_q) begin
      case (dst_q)
        DstX0: begin x0_q <= xr_q; y0_q <= yr_q; end
        DstY0: y0_q <= yr_q;
        DstXl: begin xl_q <= xr_q; yl_q <= yr_q; end
        DstYl: yl_q <= yr_q;
        DstXm: xm_q <= xr_q;
        DstXa: begin xa_q <= xr_q; ya_q <= yr_q; end
        DstYa: ya_q <= yr_q;
        DstXb: begin xb_q <= xr_q; yb_q <= yr_q; end
        default: xm_q <= xr_q;
      endcase
    end
  end

  // Comparison target is the most recently captured probe register.
  logic signed [31:0] cmp_x;
  always_comb begin
    case (dst_q)
      DstX0: cmp_x = x0_q;
      DstXl: cmp_x = xl_q;
      default: cmp_x = xm_q;
    endcase
  end
  assign sts_o.q_lt_x = q_q < cmp_x;
  assign sts_o.q_gt_x = q_q > cmp_x;

  // Segment arithmetic.
  logic signed [32:0] dx, dy, dd;
  logic [32:0] mdx, mdy, mdd;
  assign dx = 33'(xb_q) - 33'(xa_q);
  assign dy = 33'(yb_q) - 33'(ya_q);
  assign dd = 33'(q_q) - 33'(xa_q);
  assign mdx = dx[32] ? 33'(-dx) : dx;
  assign mdy = dy[32] ? 33'(-dy) : dy;
  assign mdd = dd[32] ? 33'(-dd) : dd;
  assign sts_o.dx_zero = (dx == 33'sd0);

  logic [65:0] num_q, rem_q;
  logic [32:0] den_q;
  logic [6:0] cnt_q;
  logic neg_q;
  logic [66:0] trial;
  assign trial = {rem_q, num_q[65]} - {34'd0, den_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= 66'(mdy) * 66'(mdd);
      rem_q <= '0;
      den_q <= mdx;
      cnt_q <= 7'd0;
      neg_q <= (dy[32] ^ dd[32]) ^ dx[32];
    end else if (cmd_i.div_step) begin
      if (!trial[66]) begin
        rem_q <= trial[65:0];
        num_q <= {num_q[64:0], 1'b1};
      end else begin
        rem_q <= {rem_q[64:0], num_q[65]};
        num_q <= {num_q[64:0], 1'b0};
      end
      cnt_q <= cnt_q + 7'd1;
    end
  end
  assign sts_o.div_done = (cnt_q == 7'd66);

  // Quotient sits in num_q after 66 steps; clamp then add.
  logic [34:0] quo_c;
  logic signed [35:0] delta, sum;
  assign quo_c = (num_q > 66'h200000000) ? 35'h200000000 : num_q[34:0];
  assign delta = neg_q ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});
  assign sum = 36'(ya_q) + delta;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      range_status_o <= status_i;
      segment_index_o <= seg_i;
      if (status_i == StLow) result_y_o <= y0_q;
      else if (status_i == StHigh || use_last_i) result_y_o <= yl_q;
      else if (sts_o.dx_zero) result_y_o <= ya_q;
      else if (sum > 36'sh7FFFFFFF) result_y_o <= 32'h7FFFFFFF;
      else if (sum < -36'sh80000000) result_y_o <= 32'h80000000;
      else result_y_o <= sum[31:0];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tli_ctrl.sv =====
// Controller: handshake, clamp tests, binary search and divider sequencing.
// Depends on tli_pkg.
`default_nettype none
module tli_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 command_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  wire                 cfg_we_i,
  input  wire [8:0]           cfg_wdata_i,
  input  tli_pkg::sts_t       sts_i,
  output tli_pkg::cmd_t       cmd_o,
  output logic [1:0]          status_o,
  output logic [7:0]          seg_o,
  output logic                use_last_o
);
  import tli_pkg::*;

  localparam logic [4:0] SIdle = 5'd0, SRd0 = 5'd1, SRdL = 5'd2, SW0 = 5'd3,
                         SWl = 5'd4, SChk = 5'd5, SProbe = 5'd6, SPw = 5'd7,
                         SPc = 5'd8, SRa = 5'd9, SRb = 5'd10, SWb = 5'd11,
                         SDiv = 5'd12, SFin = 5'd13, SOut = 5'd14, SGap = 5'd15,
                         SStart = 5'd16;

  logic [4:0] st_q, st_d;
  logic [8:0] cnt_q;
  logic [CntW-1:0] n_q, lo_q, lo_d, hi_q, hi_d;
  logic [1:0] status_q, status_d;
  logic lt0_q, lt0_d;
  logic acc;

  assign in_stall_o = !(st_q == SIdle);
  assign acc = in_valid_i && !in_stall_o;
  assign out_valid_o = (st_q == SOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 9'd2;
    else if (cfg_we_i) cnt_q <= cfg_wdata_i;
  end

  logic [CntW-1:0] n_act, mid;
  assign n_act = (cnt_q < 9'd2) ? CntW'(2) : (cnt_q > 9'(TableDepth)) ? CntW'(TableDepth)
                                           : CntW'(cnt_q);
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    st_d = st_q;
    lo_d = lo_q;
    hi_d = hi_q;
    status_d = status_q;
    lt0_d = lt0_q;
    cmd_o = '0;
    cmd_o.rd_dst = DstX0;
    case (st_q)
      SIdle: if (acc) begin
        if (command_i == CmdLoad) begin
          cmd_o.write = 1'b1;
          st_d = SGap;
        end else begin
          cmd_o.latch_q = 1'b1;
          st_d = SRd0;
        end
      end
      SRd0: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_addr = '0; cmd_o.rd_dst = DstX0;
        st_d = SRdL;
      end
      SRdL: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(n_q - CntW'(1));
        cmd_o.rd_dst = DstXl; st_d = SW0;
      end
      SW0: begin
        cmd_o.rd_dst = DstX0; st_d = SWl;
      end
      SWl: begin
        lt0_d = sts_i.q_lt_x; cmd_o.rd_dst = DstXl; st_d = SChk;
      end
      SChk: begin
        cmd_o.rd_dst = DstXl;
        if (lt0_q) begin status_d = StLow; lo_d = '0; st_d = SFin; end
        else if (sts_i.q_gt_x) begin
          status_d = StHigh; lo_d = n_q - CntW'(1); st_d = SFin;
        end else begin
          status_d = StInside; lo_d = '0; hi_d = n_q; st_d = SProbe;
        end
      end
      SProbe: begin
        cmd_o.rd_dst = DstXm;
        if (hi_q - lo_q > CntW'(1)) begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(mid); st_d = SPw;
        end else if (lo_q >= n_q - CntW'(1)) st_d = SFin;
        else st_d = SRa;
      end
      SPw: begin cmd_o.rd_dst = DstXm; st_d = SPc; end
      SPc: begin
        cmd_o.rd_dst = DstXm;
        if (sts_i.q_lt_x) hi_d = mid; else lo_d = mid;
        st_d = SProbe;
      end
      SRa: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(lo_q); cmd_o.rd_dst = DstXa;
        st_d = SRb;
      end
      SRb: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_addr = IdxW'(lo_q + CntW'(1));
        cmd_o.rd_dst = DstXb; st_d = SWb;
      end
      SWb: begin cmd_o.rd_dst = DstXb; st_d = SStart; end
      // Both segment ends are captured by now, so the divider can be primed.
      SStart: begin cmd_o.rd_dst = DstXb; cmd_o.div_start = 1'b1; st_d = SDiv; end
      SDiv: begin
        cmd_o.rd_dst = DstXb;
        if (lo_d == lo_q && !sts_i.div_done && hi_q != '0) cmd_o.div_step = 1'b1;
        if (sts_i.div_done) st_d = SFin;
      end
      SFin: begin cmd_o.rd_dst = DstXb; cmd_o.finish = 1'b1; st_d = SOut; end
      SOut: begin cmd_o.rd_dst = DstXb; if (!out_stall_i) st_d = SIdle; end
      SGap: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      lo_q <= '0;
      hi_q <= CntW'(1);
      status_q <= StInside;
      lt0_q <= 1'b0;
      n_q <= CntW'(2);
    end else begin
      st_q <= st_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
      status_q <= status_d;
      lt0_q <= lt0_d;
      if (acc) n_q <= n_act;
    end
  end

  assign status_o = status_d;
  assign seg_o = lo_q[7:0];
  assign use_last_o = (lo_q >= n_q - CntW'(1));
endmodule
`default_nettype wire
